@@ rtl/avd_pkg.sv @@
`default_nettype none
package avd_pkg;

  localparam int DOT_W  = 41;
  localparam int NORM_W = 40;
  localparam int ROOT_W = 31;
  localparam int DEN_W  = 62;
  localparam int Q_W    = 15;
  localparam int Z_W    = 28;
  localparam int CORD_W = 32;

  localparam logic [Q_W-1:0] ONE_Q14     = 15'd16384;
  localparam logic [Z_W-1:0] PI_Q24      = 28'd52707179;
  localparam logic [Z_W-1:0] HALF_PI_Q24 = 28'd26353589;
  localparam logic [4:0]     CORDIC_LAST = 5'd23;
  localparam logic [4:0]     SQRT_LAST   = 5'd31;
  localparam logic [4:0]     DIV_LAST    = 5'd13;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [NORM_W-1:0] norm1;
    logic [NORM_W-1:0] norm2;
    logic              too_long;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SQ1, B_SQ2, B_MUL, B_PRE, B_DIV, B_SQL, B_SQ3, B_CORD, B_DONE
  } back_state_t;

  function automatic logic [Z_W-1:0] atan_q24(input logic [4:0] i);
    logic [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = 28'd13176795;
      5'd1:  v = 28'd7778716;
      5'd2:  v = 28'd4110060;
      5'd3:  v = 28'd2086331;
      5'd4:  v = 28'd1047214;
      5'd5:  v = 28'd524117;
      5'd6:  v = 28'd262123;
      5'd7:  v = 28'd131069;
      5'd8:  v = 28'd65536;
      5'd9:  v = 28'd32768;
      5'd10: v = 28'd16384;
      5'd11: v = 28'd8192;
      5'd12: v = 28'd4096;
      5'd13: v = 28'd2048;
      5'd14: v = 28'd1024;
      5'd15: v = 28'd512;
      5'd16: v = 28'd256;
      5'd17: v = 28'd128;
      5'd18: v = 28'd64;
      5'd19: v = 28'd32;
      5'd20: v = 28'd16;
      5'd21: v = 28'd8;
      5'd22: v = 28'd4;
      5'd23: v = 28'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/avd_front.sv @@
`default_nettype none
module avd_front #(
  parameter int MAX_LENGTH  = 512,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   acc_en,
  input  wire logic [VALUE_WIDTH-1:0] first_value,
  input  wire logic [VALUE_WIDTH-1:0] second_value,
  input  wire logic                   last_element,
  output logic                        push,
  output avd_pkg::job_t               job
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 2);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LENGTH);
  localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(MAX_LENGTH + 1);

  logic [avd_pkg::DOT_W-1:0]  dot_r, dot_nxt;
  logic [avd_pkg::NORM_W-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [2*VALUE_WIDTH-1:0] pab, paa, pbb;
  logic signed [63:0] wab, waa, wbb;
  logic [avd_pkg::DOT_W-1:0]  dot_add;
  logic [avd_pkg::NORM_W-1:0] n1_add, n2_add;
  logic [CNT_W-1:0]           cnt_add;

  always_comb begin
    pab = $signed(first_value) * $signed(second_value);
    paa = $signed(first_value) * $signed(first_value);
    pbb = $signed(second_value) * $signed(second_value);
    wab = 64'(pab);
    waa = 64'(paa);
    wbb = 64'(pbb);
    if (cnt_r < MAX_CNT) begin
      dot_add = dot_r + wab[avd_pkg::DOT_W-1:0];
      n1_add  = n1_r + waa[avd_pkg::NORM_W-1:0];
      n2_add  = n2_r + wbb[avd_pkg::NORM_W-1:0];
      cnt_add = cnt_r + 1'b1;
    end else begin
      dot_add = dot_r;
      n1_add  = n1_r;
      n2_add  = n2_r;
      cnt_add = OVER_CNT;
    end
    job.dot      = dot_add;
    job.norm1    = n1_add;
    job.norm2    = n2_add;
    job.too_long = (cnt_add > MAX_CNT);
    push = acc_en && last_element;
    dot_nxt = dot_r;
    n1_nxt  = n1_r;
    n2_nxt  = n2_r;
    cnt_nxt = cnt_r;
    if (acc_en) begin
      if (last_element) begin
        dot_nxt = '0;
        n1_nxt  = '0;
        n2_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        dot_nxt = dot_add;
        n1_nxt  = n1_add;
        n2_nxt  = n2_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      n1_r  <= '0;
      n2_r  <= '0;
      cnt_r <= '0;
    end else begin
      dot_r <= dot_nxt;
      n1_r  <= n1_nxt;
      n2_r  <= n2_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/avd_queue.sv @@
`default_nettype none
module avd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire avd_pkg::job_t  push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                q_valid,
  output avd_pkg::job_t       q_job
);

  avd_pkg::job_t slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == 2'd2);
    q_valid = (cnt_r != 2'd0);
    q_job   = slot_r[rp_r];
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/avd_back.sv @@
`default_nettype none
module avd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire avd_pkg::job_t q_job,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata,
  output logic [1:0]         out_tuser
);

  avd_pkg::back_state_t st_r, st_nxt;
  logic [63:0] sv_r, sv_nxt, sr_r, sr_nxt, sb_r, sb_nxt;
  logic [63:0] s_sum, s_v, s_r, s_b;
  logic        s_ge;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [avd_pkg::DOT_W-1:0]  mag_r, mag_nxt;
  logic [avd_pkg::NORM_W-1:0] n2_r, n2_nxt;
  logic [avd_pkg::ROOT_W-1:0] r1_r, r1_nxt;
  logic [avd_pkg::DEN_W-1:0]  den_r, den_nxt;
  logic [63:0] rem_r, rem_nxt, rem2;
  logic [avd_pkg::Q_W-1:0] q_r, q_nxt, q2;
  logic [29:0] qsq;
  logic signed [avd_pkg::CORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, shx, shy;
  logic signed [avd_pkg::Z_W-1:0] z_r, z_nxt, zc;
  logic [avd_pkg::Z_W-1:0] a_sum;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] angle;
  logic        ov_r, ov_nxt;
  logic [15:0] od_r, od_nxt;
  logic [1:0]  ou_r, ou_nxt;

  always_comb begin
    s_sum = sr_r + sb_r;
    s_ge  = (sv_r >= s_sum);
    s_v   = s_ge ? (sv_r - s_sum) : sv_r;
    s_r   = s_ge ? ((sr_r >> 1) + sb_r) : (sr_r >> 1);
    s_b   = sb_r >> 2;
    rem2  = rem_r << 1;
    q2    = q_r << 1;
    qsq   = 30'(q_r) * 30'(q_r);
    shx   = cx_r >>> cnt_r;
    shy   = cy_r >>> cnt_r;
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > $signed(avd_pkg::HALF_PI_Q24)) begin
      zc = $signed(avd_pkg::HALF_PI_Q24);
    end else begin
      zc = z_r;
    end
    a_sum = (neg_r ? (avd_pkg::PI_Q24 - $unsigned(zc)) : $unsigned(zc)) + 28'd512;
    angle = (status_r == avd_pkg::ST_OK) ? a_sum[25:10] : 16'd0;

    st_nxt     = st_r;
    sv_nxt     = sv_r;
    sr_nxt     = sr_r;
    sb_nxt     = sb_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    n2_nxt     = n2_r;
    r1_nxt     = r1_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    z_nxt      = z_r;
    status_nxt = status_r;
    pop        = 1'b0;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;

    unique case (st_r)
      avd_pkg::B_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          neg_nxt = q_job.dot[avd_pkg::DOT_W-1];
          mag_nxt = q_job.dot[avd_pkg::DOT_W-1] ? (~q_job.dot + 1'b1) : q_job.dot;
          n2_nxt  = q_job.norm2;
          sv_nxt  = {4'd0, q_job.norm1, 20'd0};
          sr_nxt  = '0;
          sb_nxt  = 64'd1 << 62;
          cnt_nxt = '0;
          if (q_job.too_long) begin
            status_nxt = avd_pkg::ST_TOO_LONG;
            st_nxt     = avd_pkg::B_DONE;
          end else if (q_job.norm1 == '0 || q_job.norm2 == '0) begin
            status_nxt = avd_pkg::ST_ZERO;
            st_nxt     = avd_pkg::B_DONE;
          end else begin
            status_nxt = avd_pkg::ST_OK;
            st_nxt     = avd_pkg::B_SQ1;
          end
        end
      end
      avd_pkg::B_SQ1: begin
        sv_nxt  = s_v;
        sr_nxt  = s_r;
        sb_nxt  = s_b;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == avd_pkg::SQRT_LAST) begin
          r1_nxt = s_r[avd_pkg::ROOT_W-1:0];
          sv_nxt = {4'd0, n2_r, 20'd0};
          sr_nxt = '0;
          sb_nxt = 64'd1 << 62;
          st_nxt = avd_pkg::B_SQ2;
        end
      end
      avd_pkg::B_SQ2: begin
        sv_nxt  = s_v;
        sr_nxt  = s_r;
        sb_nxt  = s_b;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == avd_pkg::SQRT_LAST) begin
          st_nxt = avd_pkg::B_MUL;
        end
      end
      avd_pkg::B_MUL: begin
        den_nxt = avd_pkg::DEN_W'(r1_r * sr_r[avd_pkg::ROOT_W-1:0]);
        rem_nxt = {3'd0, mag_r, 20'd0};
        st_nxt  = avd_pkg::B_PRE;
      end
      avd_pkg::B_PRE: begin
        cnt_nxt = '0;
        q_nxt   = '0;
        if (rem_r >= {2'd0, den_r}) begin
          q_nxt  = avd_pkg::ONE_Q14;
          st_nxt = avd_pkg::B_SQL;
        end else begin
          st_nxt = avd_pkg::B_DIV;
        end
      end
      avd_pkg::B_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (rem2 >= {2'd0, den_r}) begin
          rem_nxt = rem2 - {2'd0, den_r};
          q_nxt   = q2 | 15'd1;
        end else begin
          rem_nxt = rem2;
          q_nxt   = q2;
        end
        if (cnt_r == avd_pkg::DIV_LAST) begin
          st_nxt = avd_pkg::B_SQL;
        end
      end
      avd_pkg::B_SQL: begin
        neg_nxt = neg_r && (q_r != '0);
        sv_nxt  = {6'd0, 30'(30'd268435456 - qsq), 28'd0};
        sr_nxt  = '0;
        sb_nxt  = 64'd1 << 62;
        cx_nxt  = $signed({3'd0, q_r, 14'd0});
        cnt_nxt = '0;
        st_nxt  = avd_pkg::B_SQ3;
      end
      avd_pkg::B_SQ3: begin
        sv_nxt  = s_v;
        sr_nxt  = s_r;
        sb_nxt  = s_b;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == avd_pkg::SQRT_LAST) begin
          cy_nxt = $signed(s_r[avd_pkg::CORD_W-1:0]);
          z_nxt  = '0;
          st_nxt = avd_pkg::B_CORD;
        end
      end
      avd_pkg::B_CORD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cy_r >= 0) begin
          cx_nxt = cx_r + shy;
          cy_nxt = cy_r - shx;
          z_nxt  = z_r + $signed(avd_pkg::atan_q24(cnt_r));
        end else begin
          cx_nxt = cx_r - shy;
          cy_nxt = cy_r + shx;
          z_nxt  = z_r - $signed(avd_pkg::atan_q24(cnt_r));
        end
        if (cnt_r == avd_pkg::CORDIC_LAST) begin
          st_nxt = avd_pkg::B_DONE;
        end
      end
      avd_pkg::B_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = angle;
          ou_nxt = status_r;
          st_nxt = avd_pkg::B_IDLE;
        end
      end
      default: st_nxt = avd_pkg::B_IDLE;
    endcase
    out_tvalid = ov_r;
    out_tdata  = od_r;
    out_tuser  = ou_r;
  end

  always_ff @(posedge clk) begin
    sv_r     <= sv_nxt;
    sr_r     <= sr_nxt;
    sb_r     <= sb_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    n2_r     <= n2_nxt;
    r1_r     <= r1_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    z_r      <= z_nxt;
    status_r <= status_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= avd_pkg::B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/angular_vector_distance.sv @@
`default_nettype none
// Angle between two vectors. Element pairs enter one per cycle on the in_ stream and
// are summed into the dot product and both squared norms; in_tlast closes a vector pair.
// Closed vectors wait in a two-entry queue for the result unit, which works one vector at
// a time with a shared bit-pair-per-cycle square root, a one-bit-per-cycle divider and a
// 24-step CORDIC; an error status skips all three. Input stalls only when both queue
// entries hold vectors not yet started. The result is out_tdata = arc cosine of the
// similarity in unsigned Q2.14 radians, and out_tuser = status (0 ok, 1 zero norm,
// 2 more than MAX_LENGTH pairs, angle then 0).
module angular_vector_distance #(
  parameter int MAX_LENGTH  = 512,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [((2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata, // first_value, second_value
  input  wire logic                in_tlast,   // last_element
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [15:0]              out_tdata,  // angle
  output logic [1:0]               out_tuser   // status
);

  logic          acc_en, push, full, q_valid, pop;
  avd_pkg::job_t job, q_job;

  assign in_tready = !full;
  assign acc_en    = in_tvalid && !full;

  avd_front #(
    .MAX_LENGTH  (MAX_LENGTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_en       (acc_en),
    .first_value  (in_tdata[VALUE_WIDTH-1:0]),
    .second_value (in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .last_element (in_tlast),
    .push         (push),
    .job          (job)
  );

  avd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  avd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
